### src/voxoc_pkg.sv
// ----------------------------------------------------------------------------
// Voxel occupancy store package
// Operation and face codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package voxoc_pkg;

  localparam int EDGE_MAX_DEF = 16;   // default largest edge length
  localparam int CAP_W        = 5;    // capacity register width
  localparam int CAP_RST      = 16;   // capacity after reset (before saturation)
  localparam int TYPE_W       = 8;    // block type width
  localparam int COORD_W      = 7;    // signed coordinate width
  localparam int NB_W         = 6;    // neighbour flag vector width
  localparam int SEL_W        = 3;    // operation / face select width
  localparam int STEP_W       = 3;    // get sequence step counter width

  // operations
  localparam logic [SEL_W-1:0] OP_SET   = 3'd0;
  localparam logic [SEL_W-1:0] OP_GET   = 3'd1;
  localparam logic [SEL_W-1:0] OP_FACE  = 3'd2;
  localparam logic [SEL_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [SEL_W-1:0] OP_FILL  = 3'd4;
  localparam logic [SEL_W-1:0] OP_ACK   = 3'd5;

  // faces
  localparam logic [SEL_W-1:0] FACE_TOP    = 3'd0;
  localparam logic [SEL_W-1:0] FACE_BOTTOM = 3'd1;
  localparam logic [SEL_W-1:0] FACE_LEFT   = 3'd2;
  localparam logic [SEL_W-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [SEL_W-1:0] FACE_FRONT  = 3'd4;
  localparam logic [SEL_W-1:0] FACE_BACK   = 3'd5;

  // get sequence: center, then +y, -y, -x, +x, +z, -z
  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_POS_Y  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NEG_Y  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_NEG_X  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_POS_X  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_POS_Z  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEG_Z  = 3'd6;

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,   // clearing pass over the whole store
    ST_IDLE  = 5'b00010,   // ready for a transfer
    ST_RD    = 5'b00100,   // store read in flight
    ST_EV    = 5'b01000,   // evaluate read data, optional write
    ST_DONE  = 5'b10000    // hand result to the output register
  } state_e;

endpackage

### src/voxel_occupancy_store.sv
// ----------------------------------------------------------------------------
// Voxel occupancy store
// Cubic store of 8-bit block types with occupied count and modified flag,
// driven by a small sequencer around one store read/compare/write unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per transfer:
//   set, get, face check, clear, fill, acknowledge modified. Every operation
//   returns exactly one result transfer on out_valid_o/out_ready_i, carrying
//   the queried type, neighbour flags, face flag and full/empty/modified.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the capacity (edge
//   length, saturated into 1..EDGE_MAX); always ready, write it while idle.
// Sequence: set, get, face check and fill pass each store access through a
//   read state and an evaluate state on the single store port pair. Set
//   makes one access; get makes seven (center, then six neighbours); face
//   check walks the face up to the first empty voxel; fill walks every voxel;
//   clear sweeps every store entry; acknowledge and unknown codes do not.
// Reset: a clearing pass writes zero to every store entry, one per cycle
//   (4096 entries at EDGE_MAX 16); in_ready_o stays low meanwhile.
// Stall: the result sits in an output register; the next item is taken
//   while it waits, and that item holds in its last step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module voxel_occupancy_store
  import voxoc_pkg::*;
#(
  parameter int EDGE_MAX = EDGE_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CAP_W-1:0]          cfg_capacity_i,
  // operation in
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SEL_W-1:0]          operation_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic signed [COORD_W-1:0] z_coord_i,
  input  logic [TYPE_W-1:0]         write_type_i,
  input  logic [SEL_W-1:0]          face_select_i,
  // result out
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [TYPE_W-1:0]         voxel_type_o,
  output logic [NB_W-1:0]           neighbour_solid_o,
  output logic                      face_full_o,
  output logic                      volume_full_o,
  output logic                      volume_empty_o,
  output logic                      modified_out_o
);

  localparam int AW     = $clog2(EDGE_MAX);             // bits per axis
  localparam int EW     = $clog2(EDGE_MAX + 1);         // edge length width
  localparam int VW     = 3 * EW;                       // edge cubed width
  localparam int ADDR_W = 3 * AW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(EDGE_MAX * EDGE_MAX * EDGE_MAX + 1);
  localparam int SW     = (EW + 1 > CAP_W) ? EW + 1 : CAP_W;
  localparam int EDGE_RST = (CAP_RST < EDGE_MAX) ? CAP_RST : EDGE_MAX;
  localparam int CNT_MAX  = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam int PW     = COORD_W + 1;                  // probe coordinate width

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                      state_q, state_d;
  logic [EW-1:0]               edge_q, edge_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        mod_q, mod_d;
  logic [ADDR_W-1:0]           swp_q, swp_d;
  logic                        sweep_item_q, sweep_item_d;
  logic                        out_valid_q, out_valid_d;

  logic [SEL_W-1:0]            op_q, op_d;
  logic [SEL_W-1:0]            face_q, face_d;
  logic [TYPE_W-1:0]           wt_q, wt_d;
  logic signed [COORD_W-1:0]   bx_q, bx_d, by_q, by_d, bz_q, bz_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [AW-1:0]               ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  logic [TYPE_W-1:0]           res_vt_q, res_vt_d;
  logic [NB_W-1:0]             res_nb_q, res_nb_d;
  logic                        res_ff_q, res_ff_d;
  logic [TYPE_W-1:0]           out_vt_q;
  logic [NB_W-1:0]             out_nb_q;
  logic                        out_ff_q;
  logic [CNT_W-1:0]            out_cnt_q;
  logic                        out_mod_q;
  logic                        out_load;
  logic                        inb_q;
  logic [2*EW-1:0]             sq_q;
  logic [VW-1:0]               vol_q;

  // store
  logic [TYPE_W-1:0]           mem_q [DEPTH];
  logic [TYPE_W-1:0]           rdata_q;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [TYPE_W-1:0]           mem_wdata;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] clamp_c(logic signed [COORD_W-1:0] v,
                                            logic [AW-1:0] hi);
    logic [PW-1:0] vu;
    vu = {1'b0, v};
    if (v[COORD_W-1]) return '0;
    else if (vu > PW'(hi)) return hi;
    else return AW'(vu);
  endfunction

  function automatic logic in_vol(logic signed [PW-1:0] p, logic [EW-1:0] e);
    logic [PW-1:0] pu;
    pu = $unsigned(p);
    return !p[PW-1] && (pu < PW'(e));
  endfunction

  // --------------------------------------------------------------------------
  // Probe position: one address per cycle from the sequencer counters
  // --------------------------------------------------------------------------
  logic [AW-1:0]          emax;
  logic signed [PW-1:0]   dx, dy, dz, gx, gy, gz;
  logic [AW-1:0]          px, py, pz;
  logic                   inb;
  logic [ADDR_W-1:0]      pos_addr;

  assign emax = AW'(edge_q - EW'(1));

  always_comb begin
    dx = '0;
    dy = '0;
    dz = '0;
    unique case (step_q)
      STEP_POS_Y: dy = PW'(1);
      STEP_NEG_Y: dy = -PW'(1);
      STEP_NEG_X: dx = -PW'(1);
      STEP_POS_X: dx = PW'(1);
      STEP_POS_Z: dz = PW'(1);
      STEP_NEG_Z: dz = -PW'(1);
      default: ;
    endcase
  end

  assign gx = {bx_q[COORD_W-1], bx_q} + dx;
  assign gy = {by_q[COORD_W-1], by_q} + dy;
  assign gz = {bz_q[COORD_W-1], bz_q} + dz;

  always_comb begin
    px  = ca_q;
    py  = cb_q;
    pz  = cc_q;
    inb = 1'b1;
    unique case (op_q)
      OP_SET: begin
        px = clamp_c(bx_q, emax);
        py = clamp_c(by_q, emax);
        pz = clamp_c(bz_q, emax);
      end
      OP_GET: begin
        px  = gx[AW-1:0];
        py  = gy[AW-1:0];
        pz  = gz[AW-1:0];
        inb = in_vol(gx, edge_q) && in_vol(gy, edge_q) && in_vol(gz, edge_q);
      end
      OP_FACE: begin
        unique case (face_q)
          FACE_BOTTOM: begin px = ca_q; py = '0;   pz = cb_q; end
          FACE_LEFT:   begin px = '0;   py = ca_q; pz = cb_q; end
          FACE_RIGHT:  begin px = emax; py = ca_q; pz = cb_q; end
          FACE_FRONT:  begin px = ca_q; py = cb_q; pz = emax; end
          FACE_BACK:   begin px = ca_q; py = cb_q; pz = '0;   end
          default:     begin px = ca_q; py = emax; pz = cb_q; end  // top
        endcase
      end
      default: ;  // fill walks ca/cb/cc directly
    endcase
  end

  assign pos_addr = {px, py, pz};

  // --------------------------------------------------------------------------
  // Set-style write decision (set uses the item's type, fill uses type 1)
  // --------------------------------------------------------------------------
  logic [TYPE_W-1:0] set_t;
  logic              wr_chg, cnt_inc, cnt_dec;

  assign set_t   = (op_q == OP_SET) ? wt_q : TYPE_W'(1);
  assign wr_chg  = (set_t != '0) ? (rdata_q != set_t) : (rdata_q != '0);
  assign cnt_inc = (set_t != '0) && (rdata_q == '0);
  assign cnt_dec = (set_t == '0) && (rdata_q != '0);

  logic face_last, fill_last, sweep_last;
  logic [STEP_W-1:0] nb_idx;

  assign face_last  = (ca_q == emax) && (cb_q == emax);
  assign fill_last  = face_last && (cc_q == emax);
  assign sweep_last = (swp_q == '1);
  assign nb_idx     = step_q - STEP_W'(1);

  // config saturation into 1..EDGE_MAX
  logic [SW-1:0] cap_ext;
  assign cap_ext = SW'(cfg_capacity_i);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    edge_d       = edge_q;
    count_d      = count_q;
    mod_d        = mod_q;
    swp_d        = swp_q;
    sweep_item_d = sweep_item_q;
    op_d         = op_q;
    face_d       = face_q;
    wt_d         = wt_q;
    bx_d         = bx_q;
    by_d         = by_q;
    bz_d         = bz_q;
    step_d       = step_q;
    ca_d         = ca_q;
    cb_d         = cb_q;
    cc_d         = cc_q;
    res_vt_d     = res_vt_q;
    res_nb_d     = res_nb_q;
    res_ff_d     = res_ff_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_addr;
    mem_wdata    = set_t;
    out_load     = 1'b0;

    if (cfg_valid_i) begin
      if (cap_ext == '0) edge_d = EW'(1);
      else if (cap_ext > SW'(EDGE_MAX)) edge_d = EW'(EDGE_MAX);
      else edge_d = EW'(cap_ext);
    end

    unique case (state_q)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = swp_q;
        mem_wdata = '0;
        swp_d     = swp_q + ADDR_W'(1);
        if (sweep_last) begin
          count_d = '0;
          state_d = sweep_item_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          face_d   = face_select_i;
          wt_d     = write_type_i;
          bx_d     = x_coord_i;
          by_d     = y_coord_i;
          bz_d     = z_coord_i;
          step_d   = STEP_CENTER;
          ca_d     = '0;
          cb_d     = '0;
          cc_d     = '0;
          res_vt_d = '0;
          res_nb_d = '0;
          res_ff_d = 1'b0;
          unique case (operation_i)
            OP_SET, OP_GET, OP_FILL: state_d = ST_RD;
            OP_FACE: state_d = (face_select_i > FACE_BACK) ? ST_DONE : ST_RD;
            OP_CLEAR: begin
              swp_d        = '0;
              sweep_item_d = 1'b1;
              state_d      = ST_SWEEP;
            end
            OP_ACK: begin
              mod_d   = 1'b0;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;   // unused codes: status only
          endcase
        end
      end

      ST_RD: state_d = ST_EV;

      ST_EV: begin
        unique case (op_q)
          OP_SET: begin
            mem_we = wr_chg;
            if (wr_chg) mod_d = 1'b1;
            if (cnt_inc) count_d = count_q + CNT_W'(1);
            if (cnt_dec) count_d = count_q - CNT_W'(1);
            state_d = ST_DONE;
          end
          OP_GET: begin
            if (step_q == STEP_CENTER) res_vt_d = inb_q ? rdata_q : '0;
            else res_nb_d[nb_idx] = inb_q && (rdata_q != '0);
            if (step_q == STEP_NEG_Z) begin
              state_d = ST_DONE;
            end else begin
              step_d  = step_q + STEP_W'(1);
              state_d = ST_RD;
            end
          end
          OP_FACE: begin
            if (rdata_q == '0) begin
              res_ff_d = 1'b0;
              state_d  = ST_DONE;
            end else if (face_last) begin
              res_ff_d = 1'b1;
              state_d  = ST_DONE;
            end else begin
              if (cb_q == emax) begin
                cb_d = '0;
                ca_d = ca_q + AW'(1);
              end else begin
                cb_d = cb_q + AW'(1);
              end
              state_d = ST_RD;
            end
          end
          default: begin  // fill
            mem_we = wr_chg;
            if (wr_chg) mod_d = 1'b1;
            if (cnt_inc) count_d = count_q + CNT_W'(1);
            if (fill_last) begin
              state_d = ST_DONE;
            end else begin
              if (cc_q == emax) begin
                cc_d = '0;
                if (cb_q == emax) begin
                  cb_d = '0;
                  ca_d = ca_q + AW'(1);
                end else begin
                  cb_d = cb_q + AW'(1);
                end
              end else begin
                cc_d = cc_q + AW'(1);
              end
              state_d = ST_RD;
            end
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load     = 1'b1;
          sweep_item_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      edge_q       <= EW'(EDGE_RST);
      count_q      <= '0;
      mod_q        <= 1'b0;
      swp_q        <= '0;
      sweep_item_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_q       <= edge_d;
      count_q      <= count_d;
      mod_q        <= mod_d;
      swp_q        <= swp_d;
      sweep_item_q <= sweep_item_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    face_q   <= face_d;
    wt_q     <= wt_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    bz_q     <= bz_d;
    step_q   <= step_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    cc_q     <= cc_d;
    res_vt_q <= res_vt_d;
    res_nb_q <= res_nb_d;
    res_ff_q <= res_ff_d;
    inb_q    <= inb;
    // edge cubed, two registered multiplies
    sq_q     <= (2*EW)'(edge_q) * (2*EW)'(edge_q);
    vol_q    <= VW'(sq_q) * VW'(edge_q);
    if (out_load) begin
      out_vt_q  <= res_vt_q;
      out_nb_q  <= res_nb_q;
      out_ff_q  <= res_ff_q;
      out_cnt_q <= count_q;
      out_mod_q <= mod_q;
    end
  end

  // --------------------------------------------------------------------------
  // Voxel store: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[pos_addr];
  end

  // --------------------------------------------------------------------------
  // Outputs; full/empty come from the count captured with the result
  // --------------------------------------------------------------------------
  assign out_valid_o       = out_valid_q;
  assign voxel_type_o      = out_vt_q;
  assign neighbour_solid_o = out_nb_q;
  assign face_full_o       = out_ff_q;
  assign volume_full_o     = (VW'(out_cnt_q) == vol_q);
  assign volume_empty_o    = (out_cnt_q == '0);
  assign modified_out_o    = out_mod_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CNT_MAX))
    else $error("occupied count above store size");

  a_sweep_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && sweep_last |=> (count_q == '0))
    else $error("count not zero after clearing pass");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted transfer");

  a_eval_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EV) |-> ($past(state_q) == ST_RD))
    else $error("evaluate without a preceding store read");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending output");

endmodule
